/* hw/rtl/fsf_pkg.sv */
// shared types and constants for the separation force block
`default_nettype none
package fsf_pkg;
	localparam int MaxNeighbors = 1024;
	localparam int CountW = 11;
	localparam int SumW = 56;
	localparam int DiffW = 33;
	localparam int RadW = 66;
	localparam int RootW = 33;
	localparam int MulAW = 64;
	localparam int MulBW = 34;
	localparam int DivNW = 56;
	localparam int DivDW = 33;
	localparam int CfgW = 31;
	localparam int StepW = 6;
	localparam logic [StepW-1:0] MulSteps = StepW'(MulBW);
	localparam logic [StepW-1:0] DivSteps = StepW'(DivNW);
	localparam logic [StepW-1:0] RootSteps = StepW'(RadW / 2);

	localparam logic CfgRadius = 1'b0;
	localparam logic CfgSpeed = 1'b1;
	localparam logic [CfgW-1:0] RadiusReset = CfgW'(1310720);
	localparam logic [CfgW-1:0] SpeedReset = CfgW'(655360);

	typedef struct packed {
		logic signed [31:0] agent_x;
		logic signed [31:0] agent_y;
		logic signed [31:0] neighbor_x;
		logic signed [31:0] neighbor_y;
		logic neighbor_valid;
		logic last;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [CountW-1:0] neighbor_total;
		logic overflow;
	} out_word_t;
endpackage
`default_nettype wire

/* hw/rtl/flock_separation_force_core.sv */
// separation steering core: sequencer, sums and result register
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    in_data (fsf_pkg::in_word_t)
// out      out  out_valid / out_stall  out_data (fsf_pkg::out_word_t)
// cfg      in   cfg_we                 cfg_index, cfg_data
// a valid neighbor is squared per component, rooted, then divided and multiplied per component
// (each unit steps bit by bit between a start and a hand-off) once the word is taken
// a zero-length offset ends after the root; an invalid or surplus word skips the units
// closing a set divides and scales each sum, an empty set skips that; in_stall is high while a word is in work
// the result sits in an output register; a new result waits while the previous one is stalled
// reset clears the sums, the count and the flags and restores both registers
`default_nettype none
module flock_separation_force_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire fsf_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output fsf_pkg::out_word_t out_data,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [fsf_pkg::CfgW-1:0] cfg_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_SQX, S_SQY, S_ROOT, S_DIVX, S_MULX, S_DIVY, S_MULY,
		S_FIN, S_FDX, S_FMX, S_FDY, S_FMY, S_EMIT
	} state_t;

	state_t state_q;
	logic [fsf_pkg::CfgW-1:0] radius_q;
	logic [fsf_pkg::CfgW-1:0] speed_q;
	logic signed [fsf_pkg::SumW-1:0] sum_x_q;
	logic signed [fsf_pkg::SumW-1:0] sum_y_q;
	logic [fsf_pkg::CountW-1:0] count_q;
	logic cnt_ovf_q;
	logic sat_q;
	logic last_q;
	logic launch_q;
	logic out_valid_q;
	fsf_pkg::out_word_t out_q;
	logic signed [fsf_pkg::DiffW-1:0] dx_q;
	logic signed [fsf_pkg::DiffW-1:0] dy_q;
	logic [63:0] sx_q;
	logic [fsf_pkg::RootW-1:0] dist_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;

	logic signed [fsf_pkg::DiffW-1:0] dx_in;
	logic signed [fsf_pkg::DiffW-1:0] dy_in;
	logic [fsf_pkg::DiffW-1:0] ax;
	logic [fsf_pkg::DiffW-1:0] ay;
	logic signed [33:0] weight;
	logic [33:0] wmag;
	logic [fsf_pkg::SumW-1:0] smag_x;
	logic [fsf_pkg::SumW-1:0] smag_y;

	logic unit_state;
	logic mul_state;
	logic div_state;
	logic mul_start, div_start, root_start;
	logic mul_done, div_done, root_done;
	logic [fsf_pkg::MulAW-1:0] mul_a;
	logic [fsf_pkg::MulBW-1:0] mul_b;
	logic [fsf_pkg::MulAW-1:0] prod;
	logic [fsf_pkg::DivNW-1:0] div_n;
	logic [fsf_pkg::DivDW-1:0] div_d;
	logic [fsf_pkg::DivNW-1:0] quo;
	logic [fsf_pkg::RootW-1:0] root;

	logic [34:0] comp_mag;
	logic comp_neg;
	logic signed [fsf_pkg::SumW-1:0] comp;
	logic [47:0] fp;
	logic fneg;
	logic fsat;
	logic [47:0] fclip;
	logic [47:0] fval;

	assign dx_in = fsf_pkg::DiffW'(in_data.agent_x) - fsf_pkg::DiffW'(in_data.neighbor_x);
	assign dy_in = fsf_pkg::DiffW'(in_data.agent_y) - fsf_pkg::DiffW'(in_data.neighbor_y);
	assign ax = dx_q[fsf_pkg::DiffW-1] ? -dx_q : dx_q;
	assign ay = dy_q[fsf_pkg::DiffW-1] ? -dy_q : dy_q;
	assign weight = $signed({3'b000, radius_q}) - $signed({1'b0, dist_q});
	assign wmag = weight[33] ? -weight : weight;
	assign smag_x = sum_x_q[fsf_pkg::SumW-1] ? -sum_x_q : sum_x_q;
	assign smag_y = sum_y_q[fsf_pkg::SumW-1] ? -sum_y_q : sum_y_q;

	assign mul_state = (state_q == S_SQX) || (state_q == S_SQY) || (state_q == S_MULX)
		|| (state_q == S_MULY) || (state_q == S_FMX) || (state_q == S_FMY);
	assign div_state = (state_q == S_DIVX) || (state_q == S_DIVY)
		|| (state_q == S_FDX) || (state_q == S_FDY);
	assign unit_state = mul_state || div_state || (state_q == S_ROOT);
	assign mul_start = mul_state && !launch_q;
	assign div_start = div_state && !launch_q;
	assign root_start = (state_q == S_ROOT) && !launch_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		case (state_q)
			S_SQX: begin
				mul_a = fsf_pkg::MulAW'(ax);
				mul_b = fsf_pkg::MulBW'(ax);
			end
			S_SQY: begin
				mul_a = fsf_pkg::MulAW'(ay);
				mul_b = fsf_pkg::MulBW'(ay);
			end
			S_MULX, S_MULY: begin
				mul_a = fsf_pkg::MulAW'(quo[16:0]);
				mul_b = wmag;
			end
			S_FMX, S_FMY: begin
				mul_a = fsf_pkg::MulAW'(quo);
				mul_b = fsf_pkg::MulBW'(speed_q);
			end
			S_DIVX: begin
				div_n = fsf_pkg::DivNW'({ax, 16'h0000});
				div_d = dist_q;
			end
			S_DIVY: begin
				div_n = fsf_pkg::DivNW'({ay, 16'h0000});
				div_d = dist_q;
			end
			S_FDX: begin
				div_n = smag_x;
				div_d = fsf_pkg::DivDW'(count_q);
			end
			S_FDY: begin
				div_n = smag_y;
				div_d = fsf_pkg::DivDW'(count_q);
			end
			default: begin
			end
		endcase
	end

	// signed contribution of one component
	assign comp_mag = prod[50:16];
	assign comp_neg = ((state_q == S_MULX) ? dx_q[fsf_pkg::DiffW-1] : dy_q[fsf_pkg::DiffW-1])
		^ weight[33];
	assign comp = comp_neg ? -$signed(fsf_pkg::SumW'(comp_mag))
		: $signed(fsf_pkg::SumW'(comp_mag));

	// scale and saturate the averaged sum
	assign fp = prod[63:16];
	assign fneg = (state_q == S_FMX) ? sum_x_q[fsf_pkg::SumW-1] : sum_y_q[fsf_pkg::SumW-1];
	assign fsat = fneg ? (fp > 48'h0000_8000_0000) : (fp > 48'h0000_7FFF_FFFF);
	assign fclip = fsat ? (fneg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF) : fp;
	assign fval = fneg ? -fclip : fclip;

	fsf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(prod)
	);

	fsf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_n), .den(div_d),
		.done(div_done), .quo(quo)
	);

	fsf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(root_start),
		.rad({1'b0, 65'(sx_q) + 65'(prod)}), .done(root_done), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			radius_q <= fsf_pkg::RadiusReset;
			speed_q <= fsf_pkg::SpeedReset;
			sum_x_q <= '0;
			sum_y_q <= '0;
			count_q <= '0;
			cnt_ovf_q <= 1'b0;
			sat_q <= 1'b0;
			last_q <= 1'b0;
			launch_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fsf_pkg::CfgRadius: radius_q <= cfg_data;
					fsf_pkg::CfgSpeed: speed_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == S_EMIT && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (unit_state && !launch_q) launch_q <= 1'b1;
			if (mul_done || div_done || root_done) launch_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= in_data.last;
						if (in_data.neighbor_valid &&
							(32'(count_q) < 32'(fsf_pkg::MaxNeighbors))) begin
							count_q <= count_q + 1'b1;
							state_q <= S_SQX;
						end else begin
							if (in_data.neighbor_valid) cnt_ovf_q <= 1'b1;
							if (in_data.last) state_q <= S_FIN;
						end
					end
				end
				S_SQX: if (mul_done) state_q <= S_SQY;
				S_SQY: if (mul_done) state_q <= S_ROOT;
				S_ROOT: begin
					if (root_done) begin
						if (root != '0) state_q <= S_DIVX;
						else state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_DIVX: if (div_done) state_q <= S_MULX;
				S_MULX: begin
					if (mul_done) begin
						sum_x_q <= sum_x_q + comp;
						state_q <= S_DIVY;
					end
				end
				S_DIVY: if (div_done) state_q <= S_MULY;
				S_MULY: begin
					if (mul_done) begin
						sum_y_q <= sum_y_q + comp;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					sat_q <= 1'b0;
					state_q <= (count_q != '0) ? S_FDX : S_EMIT;
				end
				S_FDX: if (div_done) state_q <= S_FMX;
				S_FMX: begin
					if (mul_done) begin
						if (fsat) sat_q <= 1'b1;
						state_q <= S_FDY;
					end
				end
				S_FDY: if (div_done) state_q <= S_FMY;
				S_FMY: begin
					if (mul_done) begin
						if (fsat) sat_q <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						sum_x_q <= '0;
						sum_y_q <= '0;
						count_q <= '0;
						cnt_ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			dx_q <= dx_in;
			dy_q <= dy_in;
		end
		if (state_q == S_SQX && mul_done) sx_q <= prod;
		if (state_q == S_ROOT && root_done) dist_q <= root;
		if (state_q == S_FIN) begin
			vx_q <= '0;
			vy_q <= '0;
		end
		if (state_q == S_FMX && mul_done) vx_q <= fval[31:0];
		if (state_q == S_FMY && mul_done) vy_q <= fval[31:0];
		if (state_q == S_EMIT && (!out_valid_q || !out_stall)) begin
			out_q.vel_x <= vx_q;
			out_q.vel_y <= vy_q;
			out_q.neighbor_total <= count_q;
			out_q.overflow <= cnt_ovf_q || sat_q;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule
`default_nettype wire

/* hw/rtl/fsf_mul.sv */
// bit-serial shift-add multiplier, product kept modulo 2^64
`default_nettype none
module fsf_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [fsf_pkg::MulAW-1:0] a,
	input wire logic [fsf_pkg::MulBW-1:0] b,
	output logic done,
	output logic [fsf_pkg::MulAW-1:0] prod
);
	logic [fsf_pkg::MulAW-1:0] a_q;
	logic [fsf_pkg::MulBW-1:0] b_q;
	logic [fsf_pkg::MulAW-1:0] acc_q;
	logic [fsf_pkg::StepW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= fsf_pkg::MulSteps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fsf_pkg::StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[fsf_pkg::MulAW-2:0], 1'b0};
			b_q <= {1'b0, b_q[fsf_pkg::MulBW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

/* hw/rtl/fsf_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module fsf_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [fsf_pkg::DivNW-1:0] num,
	input wire logic [fsf_pkg::DivDW-1:0] den,
	output logic done,
	output logic [fsf_pkg::DivNW-1:0] quo
);
	logic [fsf_pkg::DivNW-1:0] q_q;
	logic [fsf_pkg::DivDW-1:0] d_q;
	logic [fsf_pkg::DivDW-1:0] rem_q;
	logic [fsf_pkg::StepW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [fsf_pkg::DivDW:0] rem2;
	logic [fsf_pkg::DivDW:0] diff;

	assign rem2 = {rem_q, q_q[fsf_pkg::DivNW-1]};
	assign diff = rem2 - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= fsf_pkg::DivSteps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fsf_pkg::StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			d_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (rem2 >= {1'b0, d_q}) begin
				rem_q <= diff[fsf_pkg::DivDW-1:0];
				q_q <= {q_q[fsf_pkg::DivNW-2:0], 1'b1};
			end else begin
				rem_q <= rem2[fsf_pkg::DivDW-1:0];
				q_q <= {q_q[fsf_pkg::DivNW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = q_q;
endmodule
`default_nettype wire

/* hw/rtl/fsf_sqrt.sv */
// integer square root, two radicand bits per cycle
`default_nettype none
module fsf_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [fsf_pkg::RadW-1:0] rad,
	output logic done,
	output logic [fsf_pkg::RootW-1:0] root
);
	logic [fsf_pkg::RadW-1:0] rad_q;
	logic [34:0] rem_q;
	logic [fsf_pkg::RootW-1:0] root_q;
	logic [fsf_pkg::StepW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [36:0] rem2;
	logic [36:0] trial;
	logic [36:0] diff;

	assign rem2 = {rem_q, rad_q[fsf_pkg::RadW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff = rem2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= fsf_pkg::RootSteps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fsf_pkg::StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[fsf_pkg::RadW-3:0], 2'b00};
			if (rem2 >= trial) begin
				rem_q <= diff[34:0];
				root_q <= {root_q[fsf_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_q <= rem2[34:0];
				root_q <= {root_q[fsf_pkg::RootW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

/* dv/tb.sv */
// testbench for the separation force core: directed table, random neighbor sets, predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	fsf_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	fsf_pkg::out_word_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = fsf_pkg::CfgRadius;
	logic [fsf_pkg::CfgW-1:0] cfg_data = '0;

	flock_separation_force_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [fsf_pkg::CfgW-1:0] radius_q;
	logic [fsf_pkg::CfgW-1:0] speed_q;
	logic signed [63:0] sumx_q;
	logic signed [63:0] sumy_q;
	int unsigned count_q;
	logic cnt_ovf_q;

	fsf_pkg::out_word_t pending_vel[$];
	int errors = 0;
	bit stim_done = 1'b0;

	typedef struct {
		fsf_pkg::in_word_t w;
		bit has_exp;
		fsf_pkg::out_word_t exp;
	} row_t;
	row_t dir_rows[$];

	function automatic logic [63:0] mag64(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] root66(logic [65:0] r);
		logic [67:0] rem;
		logic [67:0] trial;
		logic [63:0] root;
		rem = '0;
		root = '0;
		for (int k = 32; k >= 0; k--) begin
			rem = (rem << 2) | r[2*k +: 2];
			trial = {root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[62:0], 1'b1};
			end else begin
				root = {root[62:0], 1'b0};
			end
		end
		return root;
	endfunction

	function automatic logic signed [63:0] steer_part(logic signed [63:0] d,
			logic [63:0] dlen, logic signed [63:0] wgt);
		logic [63:0] n;
		logic [127:0] p;
		n = (mag64(d) << 16) / dlen;
		p = (128'(n) * 128'(mag64(wgt))) >> 16;
		return ((d < 0) != (wgt < 0)) ? -$signed(p[63:0]) : $signed(p[63:0]);
	endfunction

	function automatic logic signed [31:0] settle(logic signed [63:0] s, int unsigned c,
			inout logic sat);
		logic [63:0] avg;
		logic [127:0] p;
		avg = mag64(s) / c;
		p = (128'(avg) * 128'(speed_q)) >> 16;
		if (s >= 0 && p > 128'h7FFFFFFF) begin
			sat = 1'b1;
			p = 128'h7FFFFFFF;
		end else if (s < 0 && p > 128'h80000000) begin
			sat = 1'b1;
			p = 128'h80000000;
		end
		return s < 0 ? 32'(-p[63:0]) : 32'(p[63:0]);
	endfunction

	function automatic bit separation_step(fsf_pkg::in_word_t w, output fsf_pkg::out_word_t r);
		logic signed [63:0] dx, dy, wgt;
		logic [65:0] sq;
		logic [63:0] dlen;
		logic sat;
		sat = 1'b0;
		r = '0;
		if (w.neighbor_valid) begin
			if (count_q < fsf_pkg::MaxNeighbors) begin
				dx = 64'(w.agent_x) - 64'(w.neighbor_x);
				dy = 64'(w.agent_y) - 64'(w.neighbor_y);
				sq = 66'(mag64(dx)) * 66'(mag64(dx)) + 66'(mag64(dy)) * 66'(mag64(dy));
				dlen = root66(sq);
				count_q++;
				if (dlen != 0) begin
					wgt = $signed(64'(radius_q)) - $signed(dlen);
					sumx_q += steer_part(dx, dlen, wgt);
					sumy_q += steer_part(dy, dlen, wgt);
				end
			end else begin
				cnt_ovf_q = 1'b1;
			end
		end
		if (!w.last) return 1'b0;
		if (count_q != 0) begin
			r.vel_x = settle(sumx_q, count_q, sat);
			r.vel_y = settle(sumy_q, count_q, sat);
		end
		r.neighbor_total = fsf_pkg::CountW'(count_q);
		r.overflow = cnt_ovf_q | sat;
		sumx_q = 0;
		sumy_q = 0;
		count_q = 0;
		cnt_ovf_q = 1'b0;
		return 1'b1;
	endfunction

	task automatic write_reg(logic idx, logic [fsf_pkg::CfgW-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fsf_pkg::CfgRadius) radius_q = v;
		else speed_q = v;
	endtask

	task automatic send_word(fsf_pkg::in_word_t w, bit has_exp, fsf_pkg::out_word_t exp);
		fsf_pkg::out_word_t r;
		int unsigned gap;
		gap = $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (separation_step(w, r)) begin
			if (has_exp && r != exp) begin
				errors++;
				$display("%0t table row disagrees with predictor: table %h predictor %h",
					$time, exp, r);
			end
			pending_vel.push_back(has_exp ? exp : r);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_vel.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rnd_pos(int unsigned mode);
		case (mode)
			0: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
			1: return $urandom;
			default: return $signed($urandom_range(0, 4096)) - 2048;
		endcase
	endfunction

	task automatic random_sets(int unsigned n_items);
		fsf_pkg::in_word_t w;
		int unsigned sent;
		int unsigned len;
		int unsigned mode;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 8);
			mode = $urandom_range(0, 5);
			w.agent_x = rnd_pos(mode % 3);
			w.agent_y = rnd_pos(mode % 3);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					w.agent_x = $urandom;
					w.agent_y = $urandom;
				end
				w.neighbor_x = (mode == 5) ? w.agent_x : w.agent_x + rnd_pos(mode % 3);
				w.neighbor_y = (mode == 5) ? w.agent_y : w.agent_y + rnd_pos(mode % 3);
				if (mode == 4) begin
					w.neighbor_x = $urandom;
					w.neighbor_y = $urandom;
				end
				w.neighbor_valid = $urandom_range(0, 5) != 0;
				w.last = (i == len - 1);
				send_word(w, 1'b0, '0);
				sent++;
			end
		end
	endtask

	function automatic fsf_pkg::in_word_t mk(int ax, int ay, int nx, int ny, bit v, bit l);
		fsf_pkg::in_word_t w;
		w.agent_x = ax;
		w.agent_y = ay;
		w.neighbor_x = nx;
		w.neighbor_y = ny;
		w.neighbor_valid = v;
		w.last = l;
		return w;
	endfunction

	function automatic fsf_pkg::out_word_t ow(int vx, int vy, int n, bit o);
		fsf_pkg::out_word_t r;
		r.vel_x = vx;
		r.vel_y = vy;
		r.neighbor_total = fsf_pkg::CountW'(n);
		r.overflow = o;
		return r;
	endfunction

	task automatic add_row(fsf_pkg::in_word_t w, bit has_exp, fsf_pkg::out_word_t exp);
		row_t r;
		r.w = w;
		r.has_exp = has_exp;
		r.exp = exp;
		dir_rows.push_back(r);
	endtask

	// random stall on the result side
	initial begin
		@(posedge arst_n);
		forever begin
			out_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 9) != 0);
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_vel.size() == 0) begin
				errors++;
				$display("%0t unexpected word: expected none actual %h", $time, out_data);
			end else begin
				fsf_pkg::out_word_t e;
				e = pending_vel.pop_front();
				if (out_data.vel_x !== e.vel_x || out_data.vel_y !== e.vel_y ||
						out_data.neighbor_total !== e.neighbor_total ||
						out_data.overflow !== e.overflow) begin
					errors++;
					$display("%0t mismatch: expected %h actual %h", $time, e, out_data);
				end
			end
		end
	end

	initial begin
		radius_q = fsf_pkg::RadiusReset;
		speed_q = fsf_pkg::SpeedReset;
		sumx_q = 0;
		sumy_q = 0;
		count_q = 0;
		cnt_ovf_q = 1'b0;

		// empty set, zero offset, a single neighbor inside and outside radius
		add_row(mk(0, 0, 0, 0, 0, 1), 1'b1, ow(0, 0, 0, 0));
		add_row(mk(5 << 16, 5 << 16, 5 << 16, 5 << 16, 1, 1), 1'b1, ow(0, 0, 1, 0));
		add_row(mk(10 << 16, 0, 0, 0, 1, 1), 1'b1, ow(100 << 16, 0, 1, 0));
		add_row(mk(0, 0, 0, 30 << 16, 1, 1), 1'b1, ow(0, 100 << 16, 1, 0));
		add_row(mk(0, 0, 1 << 16, 0, 1, 0), 1'b0, '0);
		add_row(mk(0, 0, 0, -(2 << 16), 1, 0), 1'b0, '0);
		add_row(mk(0, 0, 7, 7, 0, 0), 1'b0, '0);
		add_row(mk(0, 0, 0, 0, 1, 1), 1'b0, '0);
		// field extremes
		add_row(mk(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1, 1), 1'b0, '0);
		add_row(mk(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1, 1), 1'b0, '0);
		add_row(mk(-1, -1, 0, 0, 1, 0), 1'b0, '0);
		add_row(mk(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 1, 1), 1'b0, '0);
		add_row(mk(0, 0, 1, 0, 0, 1), 1'b1, ow(0, 0, 0, 0));

		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp);
		drain();

		// saturation with big radius and speed
		write_reg(fsf_pkg::CfgRadius, 31'h7FFFFFFF);
		write_reg(fsf_pkg::CfgSpeed, 31'h7FFFFFFF);
		send_word(mk(0, 0, 1 << 16, 1 << 16, 1, 1), 1'b0, '0);
		send_word(mk(0, 0, -(3 << 16), 0, 1, 1), 1'b0, '0);
		drain();
		// count bound: 1030 neighbors in one set
		write_reg(fsf_pkg::CfgRadius, '0);
		write_reg(fsf_pkg::CfgSpeed, '0);
		send_word(mk(0, 0, 1 << 16, 0, 1, 1), 1'b0, '0);
		drain();
		write_reg(fsf_pkg::CfgSpeed, fsf_pkg::CfgW'(1 << 16));
		for (int i = 0; i < 1030; i++)
			send_word(mk(i, 0, 0, i * 3, 1, i == 1029), 1'b0, '0);
		drain();

		write_reg(fsf_pkg::CfgRadius, fsf_pkg::RadiusReset);
		write_reg(fsf_pkg::CfgSpeed, fsf_pkg::SpeedReset);
		random_sets(220);
		drain();
		write_reg(fsf_pkg::CfgRadius, fsf_pkg::CfgW'($urandom));
		write_reg(fsf_pkg::CfgSpeed, fsf_pkg::CfgW'($urandom_range(0, 4 << 16)));
		random_sets(220);
		drain();
		write_reg(fsf_pkg::CfgRadius, fsf_pkg::CfgW'($urandom_range(0, 100 << 16)));
		write_reg(fsf_pkg::CfgSpeed, fsf_pkg::CfgW'($urandom));
		random_sets(220);
		drain();
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		if (errors == 0 && pending_vel.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/fsf_pkg.sv
hw/rtl/fsf_mul.sv
hw/rtl/fsf_div.sv
hw/rtl/fsf_sqrt.sv
hw/rtl/flock_separation_force_core.sv
dv/tb.sv
